// File: hw/rtl/apdf_pkg.sv
// Shared types and constants for the all-pass delay filter.
// Used by apdf_cfg_regs and allpass_delay_filter; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package apdf_pkg;

  localparam int unsigned GAIN_W      = 16;
  localparam int unsigned DELAY_W     = 13;
  localparam int unsigned Q_SHIFT     = 15;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned APB_ADDR_W  = 3;

  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd22938;
  localparam logic [DELAY_W-1:0] DELAY_RESET = 13'd1024;

  // register word index, taken from paddr[2]
  localparam logic REG_GAIN  = 1'b0;
  localparam logic REG_DELAY = 1'b1;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain;
    logic [DELAY_W-1:0]       delay;
  } cfg_t;

endpackage

`default_nettype wire

// File: hw/rtl/apdf_cfg_regs.sv
// APB register file of the all-pass delay filter: gain and delay length.
// Depends on apdf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module apdf_cfg_regs (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [apdf_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [apdf_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [apdf_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                   pready,
  output apdf_pkg::cfg_t                         cfg_o
);

  apdf_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[2])
        apdf_pkg::REG_GAIN:  cfg_d.gain  = pwdata[apdf_pkg::GAIN_W-1:0];
        apdf_pkg::REG_DELAY: cfg_d.delay = pwdata[apdf_pkg::DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain  <= apdf_pkg::GAIN_RESET;
      cfg_q.delay <= apdf_pkg::DELAY_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // gain reads back sign-extended
  always_comb begin
    unique case (paddr[2])
      apdf_pkg::REG_GAIN: prdata = {{(apdf_pkg::APB_DATA_W-apdf_pkg::GAIN_W){cfg_q.gain[
                                     apdf_pkg::GAIN_W-1]}}, cfg_q.gain};
      apdf_pkg::REG_DELAY: prdata = {{(apdf_pkg::APB_DATA_W-apdf_pkg::DELAY_W){1'b0}},
                                     cfg_q.delay};
      default: prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: hw/rtl/allpass_delay_filter.sv
// Schroeder all-pass filter: top level with delay memory and arithmetic.
// Depends on apdf_pkg and apdf_cfg_regs.
//
// Usage:
//  - Input stream s_axis_*: one signed sample per transaction in tdata (low
//    SAMPLE_WIDTH bits, upper bits ignored). Output stream m_axis_*: one
//    saturated all-pass sample per input transaction, same packing, zero pad.
//  - APB port: gain (Q1.15, byte address 0) and delay length in samples
//    (address 4; 0 acts as 1, above MAX_DELAY acts as MAX_DELAY). Write only
//    while no sample is in flight.
//  - Steps: the input transaction registers the sample and its single-port
//    delay memory read; then come the first multiply (MUL1), the feedback
//    sum and memory write (SUMV), the second multiply (MUL2) and the output
//    load (OUT); the next sample is taken in the cycle the result is loaded.
//  - Stall: the result waits in the output register; a new sample is still
//    taken and worked on, and it holds in its last stage until the register
//    frees up.
//  - Reset: gain 0.7, delay 1024, write pointer 0. The memory is not swept;
//    a fill mark (pointer plus wrap flag) makes never-written entries read
//    as zero, so samples are taken right after reset.
`timescale 1ns / 1ps
`default_nettype none

module allpass_delay_filter #(
  parameter int unsigned MAX_DELAY    = 4096,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // input stream; tdata: sample_in
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // output stream; tdata: sample_out
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic      [((SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // configuration
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [apdf_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [apdf_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [apdf_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                  pready
);

  localparam int unsigned SW   = SAMPLE_WIDTH;
  localparam int unsigned TW   = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int unsigned AW   = $clog2(MAX_DELAY);
  localparam int unsigned GW   = apdf_pkg::GAIN_W;
  localparam int unsigned QS   = apdf_pkg::Q_SHIFT;
  localparam int unsigned P1W  = GW + SW;       // g * d
  localparam int unsigned P2W  = GW + 1 + SW;   // (-g) * v
  localparam int unsigned DCW  = (AW + 1 > apdf_pkg::DELAY_W) ? AW + 1 : apdf_pkg::DELAY_W;

  localparam logic [AW-1:0]  LAST_POS = AW'(MAX_DELAY - 1);
  localparam logic [AW:0]    DEPTH_E  = (AW + 1)'(MAX_DELAY);
  localparam logic [DCW-1:0] DEPTH_C  = DCW'(MAX_DELAY);
  localparam logic [DCW-1:0] ONE_C    = DCW'(1);
  localparam logic [P1W-1:0] RND1     = P1W'(1) << (QS - 1);
  localparam logic [P2W-1:0] RND2     = P2W'(1) << (QS - 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL1 = 5'b00010,
    ST_SUMV = 5'b00100,
    ST_MUL2 = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

  apdf_pkg::cfg_t cfg;

  apdf_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  state_e state_q, state_d;

  logic [AW-1:0]         wp_q, wp_d;
  logic                  wrapped_q, wrapped_d;
  logic                  rd_ok_q;
  logic [SW-1:0]         rd_data_q;
  logic signed [SW-1:0]  x_q, d_q, v_q;
  logic signed [P1W-1:0] prod1_q;
  logic signed [P2W-1:0] prod2_q;
  logic [SW-1:0]         out_q;
  logic                  out_vld_q, out_vld_d;

  logic [SW-1:0]         mem [MAX_DELAY];

  logic                  in_acc;
  logic                  out_load;
  logic                  mem_we;

  // delay clamp and read address
  logic [DCW-1:0]        dly_ext, dly_clamp;
  logic [AW:0]           dly_eff, rd_sum;
  logic [AW-1:0]         rd_addr;
  logic                  rd_ok;

  always_comb begin
    dly_ext = DCW'(cfg.delay);
    priority if (dly_ext == '0) begin
      dly_clamp = ONE_C;
    end else if (dly_ext > DEPTH_C) begin
      dly_clamp = DEPTH_C;
    end else begin
      dly_clamp = dly_ext;
    end
    dly_eff = dly_clamp[AW:0];
    // wp < depth and 1 <= dly <= depth, so this stays in [0, 2*depth)
    rd_sum  = {1'b0, wp_q} + DEPTH_E - dly_eff;
    if (rd_sum >= DEPTH_E) begin
      rd_sum = rd_sum - DEPTH_E;
    end
    rd_addr = rd_sum[AW-1:0];
    rd_ok   = wrapped_q | (rd_addr < wp_q);
  end

  // arithmetic
  logic signed [SW-1:0]  d_sel;
  logic [P1W-1:0]        p1_rnd;
  logic [SW:0]           r1;
  logic [SW+1:0]         sum1;
  logic [SW-1:0]         v_sat;
  logic signed [GW:0]    neg_g;
  logic [P2W-1:0]        p2_rnd;
  logic [SW+1:0]         r2;
  logic [SW+2:0]         sum2;
  logic [SW-1:0]         y_sat;

  always_comb begin
    d_sel  = rd_ok_q ? $signed(rd_data_q) : '0;

    p1_rnd = prod1_q + RND1;
    r1     = p1_rnd[P1W-1:QS];
    sum1   = {{2{x_q[SW-1]}}, x_q} + {r1[SW], r1};
    if ((sum1[SW+1:SW-1] == '0) || (sum1[SW+1:SW-1] == '1)) begin
      v_sat = sum1[SW-1:0];
    end else begin
      v_sat = {sum1[SW+1], {(SW-1){~sum1[SW+1]}}};
    end

    neg_g  = -$signed({cfg.gain[GW-1], cfg.gain});

    p2_rnd = prod2_q + RND2;
    r2     = p2_rnd[P2W-1:QS];
    sum2   = {{3{d_q[SW-1]}}, d_q} + {r2[SW+1], r2};
    if ((sum2[SW+2:SW-1] == '0) || (sum2[SW+2:SW-1] == '1)) begin
      y_sat = sum2[SW-1:0];
    end else begin
      y_sat = {sum2[SW+2], {(SW-1){~sum2[SW+2]}}};
    end
  end

  // handshake and sequencing
  assign out_load      = (state_q == ST_OUT) & (~out_vld_q | m_axis_tready);
  assign s_axis_tready = (state_q == ST_IDLE) | out_load;
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign mem_we        = (state_q == ST_SUMV);

  always_comb begin
    state_d   = state_q;
    wp_d      = wp_q;
    wrapped_d = wrapped_q;
    out_vld_d = out_vld_q;
    if (out_vld_q & m_axis_tready) begin
      out_vld_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_MUL1;
        end
      end
      ST_MUL1: state_d = ST_SUMV;
      ST_SUMV: begin
        state_d = ST_MUL2;
        if (wp_q == LAST_POS) begin
          wp_d      = '0;
          wrapped_d = 1'b1;
        end else begin
          wp_d = wp_q + AW'(1);
        end
      end
      ST_MUL2: state_d = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          out_vld_d = 1'b1;
          state_d   = in_acc ? ST_MUL1 : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      wp_q      <= '0;
      wrapped_q <= 1'b0;
      out_vld_q <= 1'b0;
      rd_ok_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      wp_q      <= wp_d;
      wrapped_q <= wrapped_d;
      out_vld_q <= out_vld_d;
      if (in_acc) begin
        rd_ok_q <= rd_ok;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q <= $signed(s_axis_tdata[SW-1:0]);
    end
    if (state_q == ST_MUL1) begin
      d_q     <= d_sel;
      prod1_q <= $signed(cfg.gain) * d_sel;
    end
    if (state_q == ST_SUMV) begin
      v_q <= $signed(v_sat);
    end
    if (state_q == ST_MUL2) begin
      prod2_q <= neg_g * v_q;
    end
    if (out_load) begin
      out_q <= y_sat;
    end
  end

  // delay memory: one write, one registered read; the read of a new sample
  // always follows the write of the previous one
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wp_q] <= v_sat;
    end
    if (in_acc) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = TW'(out_q);

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for allpass_delay_filter: random samples in, checked samples out.
// Keeps its own copy of the delay line and registers to predict each output.
// Depends on apdf_pkg and the allpass_delay_filter RTL.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned DEPTH  = 4096;
  localparam int unsigned DATA_W = 16;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // input stream; tdata: sample_in
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata = '0;
  // output stream; tdata: sample_out
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DATA_W-1:0] m_axis_tdata;
  // config port
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [apdf_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [apdf_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [apdf_pkg::APB_DATA_W-1:0] prdata;
  logic                            pready;

  allpass_delay_filter #(
    .MAX_DELAY    (DEPTH),
    .SAMPLE_WIDTH (DATA_W)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: delay line, write pointer and shadow registers
  // ---------------------------------------------------------------------------
  logic signed [DATA_W-1:0]           delay_line [DEPTH];
  logic [11:0]                        wr_ptr;
  logic signed [apdf_pkg::GAIN_W-1:0] gain_q;
  logic [apdf_pkg::DELAY_W-1:0]       delay_q;

  logic [DATA_W-1:0] sample_in_q [$];     // samples waiting for the driver
  logic [DATA_W-1:0] expected_out_q [$];  // predicted outputs, oldest first

  int  mismatch_cnt = 0;
  bit  no_idle = 1'b0;   // phase with no gaps and no stalls
  bit  in_fire = 1'b0;   // input transaction at the last rising edge
  bit  out_fire = 1'b0;  // output transaction at the last rising edge
  int  in_gap = 0;
  int  out_stall = 0;

  function automatic longint clip_sample(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Q1.15 product rounded half up: floor((p + 2^14) / 2^15)
  function automatic longint round_q15(input longint p);
    return (p + 64'sd16384) >>> apdf_pkg::Q_SHIFT;
  endfunction

  // One all-pass step: read the delayed feedback, write the new one, return y.
  function automatic logic [DATA_W-1:0] allpass_predict(input logic [DATA_W-1:0] x_bits);
    longint x, g, d, v, y;
    int unsigned dly;
    logic [11:0] rd;
    x = longint'($signed(x_bits));
    g = longint'(gain_q);
    dly = delay_q;
    if (dly < 1) dly = 1;           // zero delay acts as one
    if (dly > DEPTH) dly = DEPTH;   // clamp to store depth
    rd = wr_ptr - 12'(dly);         // full depth reads the entry about to be written
    d = longint'(delay_line[rd]);
    v = clip_sample(x + round_q15(g * d));
    y = clip_sample(d + round_q15((-g) * v));
    delay_line[wr_ptr] = DATA_W'(v);
    wr_ptr = wr_ptr + 12'd1;
    return DATA_W'(y);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: input valid/data and output ready change at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!(s_axis_tvalid && !in_fire)) begin
        // nothing offered, or the offered sample was just taken
        if (in_gap > 0) begin
          in_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (sample_in_q.size() > 0) begin
          s_axis_tdata  <= sample_in_q.pop_front();
          s_axis_tvalid <= 1'b1;
          in_gap = no_idle ? 0 : $urandom_range(0, 3);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end

      if (out_fire) out_stall = no_idle ? 0 : $urandom_range(0, 3);
      if (out_stall > 0) begin
        out_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: transactions sampled at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    logic [DATA_W-1:0] exp_y;
    if (rst_ni) begin
      in_fire  <= s_axis_tvalid && s_axis_tready;
      out_fire <= m_axis_tvalid && m_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_out_q.size() == 0) begin
          $error("sample_out: no result expected, actual %0d", $signed(m_axis_tdata));
          mismatch_cnt++;
        end else begin
          exp_y = expected_out_q.pop_front();
          if (m_axis_tdata !== exp_y) begin
            $error("sample_out: expected %0d, actual %0d", $signed(exp_y),
                   $signed(m_axis_tdata));
            mismatch_cnt++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_out_q.push_back(allpass_predict(s_axis_tdata));
    end
  end

  // ---------------------------------------------------------------------------
  // Config writes and phase control
  // ---------------------------------------------------------------------------
  task automatic cfg_write(input logic [apdf_pkg::APB_ADDR_W-1:0] addr,
                           input logic [apdf_pkg::APB_DATA_W-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_idle();
    while (sample_in_q.size() != 0 || s_axis_tvalid || expected_out_q.size() != 0)
      @(negedge clk_i);
  endtask

  // Upper write-data bits are random: the block must ignore them.
  task automatic set_config(input logic signed [apdf_pkg::GAIN_W-1:0] g,
                            input logic [apdf_pkg::DELAY_W-1:0] dly);
    logic [apdf_pkg::APB_DATA_W-1:0] w;
    wait_idle();
    repeat (8) @(negedge clk_i);
    w = $urandom;
    w[apdf_pkg::GAIN_W-1:0] = g;
    cfg_write({apdf_pkg::REG_GAIN, 2'b00}, w);
    gain_q = g;
    w = $urandom;
    w[apdf_pkg::DELAY_W-1:0] = dly;
    cfg_write({apdf_pkg::REG_DELAY, 2'b00}, w);
    delay_q = dly;
  endtask

  function automatic logic [DATA_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2, 3:    return DATA_W'($urandom_range(0, 512) - 256);
      4:       return '0;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [apdf_pkg::GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return '0;
      default: return apdf_pkg::GAIN_W'($urandom);
    endcase
  endfunction

  // Short delays keep the feedback path busy; a few phases hit the limits.
  function automatic logic [apdf_pkg::DELAY_W-1:0] pick_delay();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return 13'd4096;
      2:       return 13'h1fff;
      3:       return apdf_pkg::DELAY_W'($urandom_range(4097, 8191));
      4:       return apdf_pkg::DELAY_W'($urandom_range(65, 4096));
      default: return apdf_pkg::DELAY_W'($urandom_range(1, 64));
    endcase
  endfunction

  initial begin
    for (int i = 0; i < DEPTH; i++) delay_line[i] = '0;
    wr_ptr  = '0;
    gain_q  = apdf_pkg::GAIN_RESET;
    delay_q = apdf_pkg::DELAY_RESET;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset values: gain 0.7, delay 1024
    sample_in_q = '{16'h7fff, 16'h8000, 16'h1234, 16'hffff};

    // full-scale gain, shortest delay: feedback saturates
    set_config(16'sh7fff, 13'd1);
    sample_in_q = '{16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h0000, 16'h0001,
                    16'hffff, 16'h4000};

    // gain of -1.0 with a zero delay (acts as one)
    set_config(16'sh8000, 13'd0);
    sample_in_q = '{16'h7fff, 16'h8000, 16'h7fff, 16'h0000, 16'hffff};

    // zero gain: pure delay
    set_config(16'sh0000, 13'd2);
    sample_in_q = '{16'd100, 16'hff9c, 16'h0000};

    // delay beyond store depth is clamped
    set_config(16'sh4000, 13'h1fff);
    sample_in_q = '{16'h5555, 16'haaaa};

    // delay equal to store depth
    set_config(16'sh599a, 13'd4096);
    sample_in_q = '{16'h7fff, 16'h8001};

    for (int ph = 0; ph < 14; ph++) begin
      set_config(pick_gain(), pick_delay());
      no_idle = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < 125; n++) sample_in_q.push_back(pick_sample());
    end

    wait_idle();
    repeat (20) @(negedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // run limit, far above the slowest legal run
  initial begin
    #1000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
